FILE: rtl/triangle_rect_overlap_test_unit_assert.svh
// ----------------------------------------------------------------------------
// triangle_rect_overlap_test_unit assertion macros
// Shared property shorthands for the overlap test unit checks.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_RECT_OVERLAP_TEST_UNIT_ASSERT_SVH
`define TRIANGLE_RECT_OVERLAP_TEST_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TROV_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked out of reset
`define TROV_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/trov_pkg.sv
// ----------------------------------------------------------------------------
// trov_pkg
// Constants, term indexing and shared types of the triangle/rectangle overlap unit.
// ----------------------------------------------------------------------------
package trov_pkg;

    localparam int FIELD_BITS         = 24;
    localparam int COORD_BITS_DEFAULT = 24;
    localparam int COORD_BITS_MAX     = 32;

    localparam int N_CORNERS    = 4;
    localparam int N_RECT_EDGES = 4;
    localparam int N_TRI_EDGES  = 3;

    localparam int N_CORNER_TERMS = N_CORNERS * N_TRI_EDGES;
    localparam int N_CROSS_TERMS  = N_RECT_EDGES * N_TRI_EDGES * 2;
    localparam int N_TERMS        = N_CORNER_TERMS + N_CROSS_TERMS;
    localparam int N_AXIS         = N_RECT_EDGES * N_TRI_EDGES * 2;

    localparam int TERM_W = $clog2(N_TERMS);
    localparam int AXIS_W = $clog2(N_AXIS);
    localparam int VTX_W  = $clog2(N_TRI_EDGES);

    // rectangle edges: two horizontal (z fixed), two vertical (x fixed)
    localparam int EDGE_LOW_Z  = 0;
    localparam int EDGE_HIGH_Z = 1;
    localparam int EDGE_LOW_X  = 2;
    localparam int EDGE_HIGH_X = 3;

    // side of a crossing test: start point / end point of the rectangle edge
    localparam int SIDE_START = 0;
    localparam int SIDE_END   = 1;

    typedef logic [TERM_W-1:0] term_idx_t;
    typedef logic [AXIS_W-1:0] axis_idx_t;
    typedef logic [VTX_W-1:0]  vtx_idx_t;

    // flags that bypass the multipliers
    typedef struct packed {
        logic              forced;
        logic [N_AXIS-1:0] axis_neg;
    } trov_side_t;

    function automatic vtx_idx_t next_vtx(input int e);
        vtx_idx_t v;
        case (e)
            0:       v = vtx_idx_t'(1);
            1:       v = vtx_idx_t'(2);
            default: v = vtx_idx_t'(0);
        endcase
        return v;
    endfunction

    function automatic term_idx_t corner_term(input int c, input int e);
        return term_idx_t'(c * N_TRI_EDGES + e);
    endfunction

    function automatic term_idx_t cross_term(input int r, input int e, input int s);
        return term_idx_t'(N_CORNER_TERMS + (r * N_TRI_EDGES + e) * 2 + s);
    endfunction

    function automatic axis_idx_t axis_bit(input int r, input int e, input int s);
        return axis_idx_t'((r * N_TRI_EDGES + e) * 2 + s);
    endfunction

endpackage

FILE: rtl/triangle_rect_overlap_test_unit.sv
// One triangle/rectangle overlap test per request, one request per clock cycle sustained
// while the consumer keeps taking results. Coordinate differences,
// 72 signed (COORD_BITS+1)-bit multipliers, product compares, and the final reduction into
// the output register each take one register stage. Every stage has its own valid bit and
// takes a new request whenever it is empty or its successor takes its contents, so empty
// slots are squeezed out while the result is held. The unit keeps no state between requests.
// ----------------------------------------------------------------------------
// triangle_rect_overlap_test_unit
// XZ-plane triangle versus axis-aligned rectangle overlap test, four-stage pipeline.
// ----------------------------------------------------------------------------
`include "triangle_rect_overlap_test_unit_assert.svh"

module triangle_rect_overlap_test_unit #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  rect_x_min,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  rect_z_min,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  rect_x_max,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  rect_z_max,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  tri_x0,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  tri_z0,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  tri_x1,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  tri_z1,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  tri_x2,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]  tri_z2,
    input  logic                                    faces_down,
    output logic                                    res_valid,
    input  logic                                    res_ready,
    output logic                                    overlaps
);
    import trov_pkg::*;

    localparam int CW = COORD_BITS;

    logic                   diff_valid, diff_ready_dn;
    logic signed [CW:0]     op_a [N_TERMS];
    logic signed [CW:0]     op_b [N_TERMS];
    logic signed [CW:0]     op_c [N_TERMS];
    logic signed [CW:0]     op_d [N_TERMS];
    trov_side_t             diff_side;

    logic                   mul_valid, mul_ready_dn;
    logic signed [2*CW+1:0] prod_p [N_TERMS];
    logic signed [2*CW+1:0] prod_q [N_TERMS];
    trov_side_t             mul_side;

    logic                   cmp_valid, cmp_ready_dn;
    logic [N_TERMS-1:0]     term_neg;
    trov_side_t             cmp_side;

    trov_diff_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .rect_x_min (rect_x_min),
        .rect_z_min (rect_z_min),
        .rect_x_max (rect_x_max),
        .rect_z_max (rect_z_max),
        .tri_x0     (tri_x0),
        .tri_z0     (tri_z0),
        .tri_x1     (tri_x1),
        .tri_z1     (tri_z1),
        .tri_x2     (tri_x2),
        .tri_z2     (tri_z2),
        .faces_down (faces_down),
        .out_valid  (diff_valid),
        .out_ready  (diff_ready_dn),
        .op_a       (op_a),
        .op_b       (op_b),
        .op_c       (op_c),
        .op_d       (op_d),
        .side       (diff_side)
    );

    trov_mul_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready_dn),
        .op_a      (op_a),
        .op_b      (op_b),
        .op_c      (op_c),
        .op_d      (op_d),
        .side_in   (diff_side),
        .out_valid (mul_valid),
        .out_ready (mul_ready_dn),
        .prod_p    (prod_p),
        .prod_q    (prod_q),
        .side_out  (mul_side)
    );

    trov_cmp_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready_dn),
        .prod_p    (prod_p),
        .prod_q    (prod_q),
        .side_in   (mul_side),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready_dn),
        .term_neg  (term_neg),
        .side_out  (cmp_side)
    );

    trov_reduce_stage u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmp_valid),
        .in_ready  (cmp_ready_dn),
        .term_neg  (term_neg),
        .side_in   (cmp_side),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .overlaps  (overlaps)
    );

    // an empty output register means every stage can take a request
    `TROV_ASSERT_IMP(a_idle_takes_req, clk, rst_n, !res_valid, req_ready)
    // a consumer that always takes results never backs up the pipeline
    `TROV_ASSERT_IMP(a_drain_takes_req, clk, rst_n, res_ready, req_ready)
    // forced overlap (flag or vertex inside) must reach the output as a hit
    `TROV_ASSERT_NXT(a_forced_hits, clk, rst_n, cmp_valid && cmp_side.forced && cmp_ready_dn, res_valid && overlaps)

endmodule

FILE: rtl/trov_diff_stage.sv
// ----------------------------------------------------------------------------
// trov_diff_stage
// Coordinate extraction, operand differences and compare-only tests.
// ----------------------------------------------------------------------------
module trov_diff_stage #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    rect_x_min,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    rect_z_min,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    rect_x_max,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    rect_z_max,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    tri_x0,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    tri_z0,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    tri_x1,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    tri_z1,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    tri_x2,
    input  logic signed [trov_pkg::FIELD_BITS-1:0]    tri_z2,
    input  logic                                      faces_down,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [COORD_BITS:0]                op_a [trov_pkg::N_TERMS],
    output logic signed [COORD_BITS:0]                op_b [trov_pkg::N_TERMS],
    output logic signed [COORD_BITS:0]                op_c [trov_pkg::N_TERMS],
    output logic signed [COORD_BITS:0]                op_d [trov_pkg::N_TERMS],
    output trov_pkg::trov_side_t                      side
);
    import trov_pkg::*;

    localparam int CW = COORD_BITS;

    logic                 valid_reg;
    logic signed [CW:0]   op_a_reg [N_TERMS];
    logic signed [CW:0]   op_b_reg [N_TERMS];
    logic signed [CW:0]   op_c_reg [N_TERMS];
    logic signed [CW:0]   op_d_reg [N_TERMS];
    logic signed [CW:0]   op_a_next [N_TERMS];
    logic signed [CW:0]   op_b_next [N_TERMS];
    logic signed [CW:0]   op_c_next [N_TERMS];
    logic signed [CW:0]   op_d_next [N_TERMS];
    trov_side_t           side_reg;
    trov_side_t           side_next;

    logic signed [CW:0]   xlo, zlo, xhi, zhi;
    logic signed [CW:0]   tx [N_TRI_EDGES];
    logic signed [CW:0]   tz [N_TRI_EDGES];
    logic signed [CW:0]   px [N_CORNERS];
    logic signed [CW:0]   pz [N_CORNERS];
    logic signed [CW:0]   ax [N_RECT_EDGES];
    logic signed [CW:0]   az [N_RECT_EDGES];
    logic signed [CW:0]   bx [N_RECT_EDGES];
    logic signed [CW:0]   bz [N_RECT_EDGES];
    logic [N_TRI_EDGES-1:0] vtx_in;

    // low COORD_BITS of the zero-padded field, sign-extended by one bit
    function automatic logic signed [CW:0] take(input logic [FIELD_BITS-1:0] f);
        logic [FIELD_BITS+COORD_BITS_MAX-1:0] wide;
        wide = {{COORD_BITS_MAX{1'b0}}, f};
        return {wide[CW-1], wide[CW-1:0]};
    endfunction

    always_comb
    begin
        xlo   = take(rect_x_min);
        zlo   = take(rect_z_min);
        xhi   = take(rect_x_max);
        zhi   = take(rect_z_max);
        tx[0] = take(tri_x0);
        tz[0] = take(tri_z0);
        tx[1] = take(tri_x1);
        tz[1] = take(tri_z1);
        tx[2] = take(tri_x2);
        tz[2] = take(tri_z2);

        // corners: bit 0 picks high x, bit 1 picks high z
        px[0] = xlo; pz[0] = zlo;
        px[1] = xhi; pz[1] = zlo;
        px[2] = xlo; pz[2] = zhi;
        px[3] = xhi; pz[3] = zhi;

        ax[EDGE_LOW_Z]  = xlo; az[EDGE_LOW_Z]  = zlo; bx[EDGE_LOW_Z]  = xhi; bz[EDGE_LOW_Z]  = zlo;
        ax[EDGE_HIGH_Z] = xlo; az[EDGE_HIGH_Z] = zhi; bx[EDGE_HIGH_Z] = xhi; bz[EDGE_HIGH_Z] = zhi;
        ax[EDGE_LOW_X]  = xlo; az[EDGE_LOW_X]  = zlo; bx[EDGE_LOW_X]  = xlo; bz[EDGE_LOW_X]  = zhi;
        ax[EDGE_HIGH_X] = xhi; az[EDGE_HIGH_X] = zlo; bx[EDGE_HIGH_X] = xhi; bz[EDGE_HIGH_X] = zhi;

        for (int i = 0; i < N_TRI_EDGES; i++)
        begin
            vtx_in[i] = (xlo <= tx[i]) && (tx[i] <= xhi) && (zlo <= tz[i]) && (tz[i] <= zhi);
        end
        side_next.forced = faces_down || (|vtx_in);

        // winding test of each corner against each triangle edge
        for (int c = 0; c < N_CORNERS; c++)
        begin
            for (int e = 0; e < N_TRI_EDGES; e++)
            begin
                op_a_next[corner_term(c, e)] = tz[e] - pz[c];
                op_b_next[corner_term(c, e)] = tx[next_vtx(e)] - tx[e];
                op_c_next[corner_term(c, e)] = tx[e] - px[c];
                op_d_next[corner_term(c, e)] = tz[next_vtx(e)] - tz[e];
            end
        end

        for (int r = 0; r < N_RECT_EDGES; r++)
        begin
            for (int e = 0; e < N_TRI_EDGES; e++)
            begin
                op_a_next[cross_term(r, e, SIDE_START)] = tz[next_vtx(e)] - tz[e];
                op_b_next[cross_term(r, e, SIDE_START)] = ax[r] - tx[next_vtx(e)];
                op_c_next[cross_term(r, e, SIDE_START)] = tx[next_vtx(e)] - tx[e];
                op_d_next[cross_term(r, e, SIDE_START)] = az[r] - tz[next_vtx(e)];
                op_a_next[cross_term(r, e, SIDE_END)]   = tz[next_vtx(e)] - tz[e];
                op_b_next[cross_term(r, e, SIDE_END)]   = bx[r] - tx[next_vtx(e)];
                op_c_next[cross_term(r, e, SIDE_END)]   = tx[next_vtx(e)] - tx[e];
                op_d_next[cross_term(r, e, SIDE_END)]   = bz[r] - tz[next_vtx(e)];

                // rectangle edges are axis-aligned, so their cross products reduce to signs
                if (r == EDGE_LOW_Z || r == EDGE_HIGH_Z)
                begin
                    side_next.axis_neg[axis_bit(r, e, SIDE_START)] =
                        ((xhi > xlo) && (tz[e] > az[r])) || ((xhi < xlo) && (tz[e] < az[r]));
                    side_next.axis_neg[axis_bit(r, e, SIDE_END)] =
                        ((xhi > xlo) && (tz[next_vtx(e)] > az[r]))
                        || ((xhi < xlo) && (tz[next_vtx(e)] < az[r]));
                end
                else
                begin
                    side_next.axis_neg[axis_bit(r, e, SIDE_START)] =
                        ((zhi > zlo) && (tx[e] < ax[r])) || ((zhi < zlo) && (tx[e] > ax[r]));
                    side_next.axis_neg[axis_bit(r, e, SIDE_END)] =
                        ((zhi > zlo) && (tx[next_vtx(e)] < ax[r]))
                        || ((zhi < zlo) && (tx[next_vtx(e)] > ax[r]));
                end
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_a_reg <= op_a_next;
            op_b_reg <= op_b_next;
            op_c_reg <= op_c_next;
            op_d_reg <= op_d_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign op_a      = op_a_reg;
    assign op_b      = op_b_reg;
    assign op_c      = op_c_reg;
    assign op_d      = op_d_reg;
    assign side      = side_reg;

endmodule

FILE: rtl/trov_mul_stage.sv
// ----------------------------------------------------------------------------
// trov_mul_stage
// Both products of every cross-product term, one multiplier each.
// ----------------------------------------------------------------------------
module trov_mul_stage #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_BITS:0]      op_a [trov_pkg::N_TERMS],
    input  logic signed [COORD_BITS:0]      op_b [trov_pkg::N_TERMS],
    input  logic signed [COORD_BITS:0]      op_c [trov_pkg::N_TERMS],
    input  logic signed [COORD_BITS:0]      op_d [trov_pkg::N_TERMS],
    input  trov_pkg::trov_side_t            side_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [2*COORD_BITS+1:0]  prod_p [trov_pkg::N_TERMS],
    output logic signed [2*COORD_BITS+1:0]  prod_q [trov_pkg::N_TERMS],
    output trov_pkg::trov_side_t            side_out
);
    import trov_pkg::*;

    localparam int PW = 2 * COORD_BITS + 2;

    logic                  valid_reg;
    logic signed [PW-1:0]  prod_p_reg [N_TERMS];
    logic signed [PW-1:0]  prod_q_reg [N_TERMS];
    logic signed [PW-1:0]  prod_p_next [N_TERMS];
    logic signed [PW-1:0]  prod_q_next [N_TERMS];
    trov_side_t            side_reg;

    always_comb
    begin
        for (int t = 0; t < N_TERMS; t++)
        begin
            prod_p_next[t] = PW'(op_a[t]) * PW'(op_b[t]);
            prod_q_next[t] = PW'(op_c[t]) * PW'(op_d[t]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_p_reg <= prod_p_next;
            prod_q_reg <= prod_q_next;
            side_reg   <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign prod_p    = prod_p_reg;
    assign prod_q    = prod_q_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/trov_cmp_stage.sv
// ----------------------------------------------------------------------------
// trov_cmp_stage
// Sign of each product difference, taken as a signed compare.
// ----------------------------------------------------------------------------
module trov_cmp_stage #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [2*COORD_BITS+1:0]   prod_p [trov_pkg::N_TERMS],
    input  logic signed [2*COORD_BITS+1:0]   prod_q [trov_pkg::N_TERMS],
    input  trov_pkg::trov_side_t             side_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [trov_pkg::N_TERMS-1:0]     term_neg,
    output trov_pkg::trov_side_t             side_out
);
    import trov_pkg::*;

    logic                valid_reg;
    logic [N_TERMS-1:0]  term_neg_reg;
    logic [N_TERMS-1:0]  term_neg_next;
    trov_side_t          side_reg;

    // p - q < 0 exactly when p < q, no wider subtractor needed
    always_comb
    begin
        for (int t = 0; t < N_TERMS; t++)
        begin
            term_neg_next[t] = prod_p[t] < prod_q[t];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            term_neg_reg <= term_neg_next;
            side_reg     <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign term_neg  = term_neg_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/trov_reduce_stage.sv
// ----------------------------------------------------------------------------
// trov_reduce_stage
// Combines corner, crossing and forced tests into the registered result.
// ----------------------------------------------------------------------------
module trov_reduce_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [trov_pkg::N_TERMS-1:0]  term_neg,
    input  trov_pkg::trov_side_t          side_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          overlaps
);
    import trov_pkg::*;

    logic                     valid_reg;
    logic                     overlaps_reg;
    logic                     overlaps_next;
    logic [N_CORNERS-1:0]     corner_hit;
    logic [N_AXIS/2-1:0]      edge_hit;

    always_comb
    begin
        // a corner is inside unless some edge product goes negative
        for (int c = 0; c < N_CORNERS; c++)
        begin
            corner_hit[c] = !term_neg[corner_term(c, 0)] && !term_neg[corner_term(c, 1)]
                            && !term_neg[corner_term(c, 2)];
        end
        // both segments must split the other's endpoints
        for (int r = 0; r < N_RECT_EDGES; r++)
        begin
            for (int e = 0; e < N_TRI_EDGES; e++)
            begin
                edge_hit[r * N_TRI_EDGES + e] =
                    (side_in.axis_neg[axis_bit(r, e, SIDE_START)]
                     != side_in.axis_neg[axis_bit(r, e, SIDE_END)])
                    && (term_neg[cross_term(r, e, SIDE_START)]
                        != term_neg[cross_term(r, e, SIDE_END)]);
            end
        end
        overlaps_next = side_in.forced || (|corner_hit) || (|edge_hit);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            overlaps_reg <= overlaps_next;
        end
    end

    assign out_valid = valid_reg;
    assign overlaps  = overlaps_reg;

endmodule
